// File: rtl/core/length_prefixed_record_parser_macros.svh
// Assertion macros for the record parser
`ifndef LENGTH_PREFIXED_RECORD_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define LPRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record parser check failed");
// Next-cycle implication, checked outside reset
`define LPRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record parser check failed");
`else
`define LPRP_ASSERT_IMP(label, ante, cons)
`define LPRP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/core/lprp_pkg.sv
package lprp_pkg;

    // Sizing defaults
    localparam int RECORD_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Record layout
    localparam int HEADER_BYTES = 5;
    localparam int BASE_FIELDS  = 2;

    // Port widths
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] MAX_ALT_RST   = 4'd4;
    localparam logic [CFG_DATA_W-1:0] MAX_WRONG_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ALT   = 1'b0,
        CFG_MAX_WRONG = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LONG    = 3'd1,
        ST_TOO_SHORT   = 3'd2,
        ST_COUNT_LIMIT = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_OVERFLOW    = 3'd5
    } status_t;

    // One parsed result on its way from the front to the back
    typedef struct packed {
        logic        text_valid;
        logic [7:0]  text_byte;
        logic [9:0]  text_offset;
        logic [4:0]  field_number;
        logic        field_done;
        logic        record_done;
        status_t     status;
        logic [7:0]  difficulty;
        logic [15:0] year;
        logic [7:0]  alt_count;
        logic [7:0]  wrong_count;
    } result_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: rtl/core/length_prefixed_record_parser.sv
// Channel   Dir  Handshake                Payload
// cfg       in   cfg_we                   cfg_index, cfg_data
// s_        in   s_tvalid / s_tready      s_tdata (data_byte), s_tlast (last)
// m_        out  m_tvalid / m_tready      m_tdata, m_tuser, m_tlast (record_done)
//
// One record byte is taken per cycle while the result queue has room, with one result per byte.
// A result enters the result queue when its byte is taken, then moves into the m_ register.
// Reset clears the parser and returns the limits to 4 alternates, 8 distractors.
// A four-entry result queue sits between the parser and the output register;
// s_tready falls only while that queue is full.
`include "length_prefixed_record_parser_macros.svh"
module length_prefixed_record_parser #(
    parameter int RECORD_BYTES = lprp_pkg::RECORD_BYTES_DEF,
    parameter int QUEUE_DEPTH  = lprp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lprp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lprp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte[7:0]
    input  logic [lprp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // text_byte[7:0], text_offset[17:8], field_number[22:18], status[25:23],
    // difficulty[33:26], year[49:34], alt_count[57:50], wrong_count[65:58], zero fill
    output logic [lprp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // text_valid[0], field_done[1]
    output logic [lprp_pkg::OUT_TUSER_W-1:0]  m_tuser,
    output logic                              m_tlast
);
    import lprp_pkg::*;

    queue_stat_t q_stat;
    result_t     front_res;
    result_t     q_entry;
    logic        push;
    logic        pop;
    logic        end_status_ok;

    lprp_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .res       (front_res)
    );

    lprp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (front_res),
        .pop      (pop),
        .rd_entry (q_entry),
        .stat     (q_stat)
    );

    lprp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A text byte on the record end leaves the record good or cut short
    assign end_status_ok = (m_tdata[25:23] == ST_OK) || (m_tdata[25:23] == ST_OVERRUN);

    `LPRP_ASSERT_IMP(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty))
    `LPRP_ASSERT_NXT(a_pop_frees, pop && !push, !q_stat.full)
    `LPRP_ASSERT_IMP(a_mid_record_quiet, m_tvalid && !m_tlast, m_tdata[65:23] == '0)
    `LPRP_ASSERT_IMP(a_text_status, m_tvalid && m_tlast && m_tuser[0], end_status_ok)

endmodule

// File: rtl/core/lprp_front.sv
module lprp_front #(
    parameter int RECORD_BYTES = lprp_pkg::RECORD_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lprp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lprp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    input  lprp_pkg::queue_stat_t            q_stat,
    output logic                             push,
    output lprp_pkg::result_t                res
);
    import lprp_pkg::*;

    localparam int BS_W  = $clog2(RECORD_BYTES + 2);
    localparam int POS_W = $clog2(RECORD_BYTES + 1);
    localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_TEXT,
        PH_TAIL,
        PH_FAILED
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [BS_W-1:0]       bs_reg, bs_next;
    logic [7:0]            len_lo_reg, len_lo_next;
    logic [15:0]           rem_reg, rem_next;
    logic [4:0]            field_reg, field_next;
    logic [5:0]            exp_reg, exp_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]            hdr_reg [HEADER_BYTES];
    logic [7:0]            hdr_next [HEADER_BYTES];
    status_t               err_reg, err_next;
    logic [CFG_DATA_W-1:0] max_alt_reg, max_alt_next;
    logic [CFG_DATA_W-1:0] max_wrong_reg, max_wrong_next;

    logic [15:0]           len;
    logic [SUM_W-1:0]      need;
    logic                  text_step;
    logic                  finish;
    status_t               err_v;
    status_t               st;

    // Accept whenever the queue has room
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    assign len  = {in_byte, len_lo_reg};
    assign need = SUM_W'(pos_reg) + SUM_W'(len) + SUM_W'(1);

    // Configuration registers
    always_comb
    begin
        max_alt_next   = max_alt_reg;
        max_wrong_next = max_wrong_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_ALT:   max_alt_next   = cfg_data;
                CFG_MAX_WRONG: max_wrong_next = cfg_data;
                default:       max_alt_next   = max_alt_reg;
            endcase
        end
    end

    // Parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        bs_next     = bs_reg;
        len_lo_next = len_lo_reg;
        rem_next    = rem_reg;
        field_next  = field_reg;
        exp_next    = exp_reg;
        hdr_next    = hdr_reg;
        err_v       = err_reg;
        text_step   = 1'b0;
        finish      = 1'b0;
        st          = ST_OK;

        res              = '0;
        res.record_done  = in_last;

        if (push)
        begin
            if (bs_reg <= BS_W'(RECORD_BYTES))
                bs_next = bs_reg + BS_W'(1);

            if (bs_reg >= BS_W'(RECORD_BYTES))
            begin
                phase_next = PH_FAILED;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (bs_reg < BS_W'(HEADER_BYTES))
                            hdr_next[bs_reg[2:0]] = in_byte;
                        if (bs_reg == BS_W'(HEADER_BYTES - 1))
                        begin
                            if (hdr_reg[3] > {4'b0, max_alt_reg} ||
                                in_byte > {4'b0, max_wrong_reg})
                            begin
                                err_v      = ST_COUNT_LIMIT;
                                phase_next = PH_FAILED;
                            end
                            else
                            begin
                                exp_next   = 6'(BASE_FIELDS) + 6'(hdr_reg[3]) + 6'(in_byte);
                                phase_next = PH_LEN_LO;
                            end
                        end
                    end
                    PH_LEN_LO:
                    begin
                        len_lo_next = in_byte;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        if (need > SUM_W'(RECORD_BYTES))
                            err_v = ST_OVERFLOW;
                        rem_next = len;
                        if (len == 16'd0)
                        begin
                            if (err_v == ST_OK)
                            begin
                                res.field_done   = 1'b1;
                                res.field_number = field_reg;
                                res.text_offset  = 10'(pos_reg);
                            end
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TEXT;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (err_reg == ST_OK)
                        begin
                            res.text_valid   = 1'b1;
                            res.text_byte    = in_byte;
                            res.text_offset  = 10'(pos_reg);
                            res.field_number = field_reg;
                        end
                        text_step = 1'b1;
                        rem_next  = rem_reg - 16'd1;
                        if (rem_reg == 16'd1)
                        begin
                            if (err_reg == ST_OK)
                                res.field_done = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    PH_TAIL, PH_FAILED:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = PH_FAILED;
                    end
                endcase
            end

            // Close the field: reserve the terminator slot
            if (finish)
            begin
                if (err_v != ST_OK)
                    phase_next = PH_FAILED;
                else if ({1'b0, field_reg} + 6'd1 >= exp_reg)
                    phase_next = PH_TAIL;
                else
                begin
                    field_next = field_reg + 5'd1;
                    phase_next = PH_LEN_LO;
                end
            end
        end

        pos_next = pos_reg + POS_W'(text_step) + POS_W'(finish);
        err_next = err_v;

        // Report the record and drop its state
        if (push && in_last)
        begin
            if (bs_next > BS_W'(RECORD_BYTES))
                st = ST_TOO_LONG;
            else if (bs_next < BS_W'(HEADER_BYTES))
                st = ST_TOO_SHORT;
            else if (err_v == ST_COUNT_LIMIT)
                st = ST_COUNT_LIMIT;
            else if (phase_next != PH_TAIL && phase_next != PH_FAILED)
                st = ST_OVERRUN;
            else if (err_v == ST_OVERFLOW)
                st = ST_OVERFLOW;
            else
                st = ST_OK;

            res.status      = st;
            res.difficulty  = hdr_next[0];
            res.year        = {hdr_next[2], hdr_next[1]};
            res.alt_count   = hdr_next[3];
            res.wrong_count = hdr_next[4];

            phase_next  = PH_HEADER;
            bs_next     = '0;
            len_lo_next = '0;
            rem_next    = '0;
            field_next  = '0;
            exp_next    = '0;
            pos_next    = '0;
            err_next    = ST_OK;
            for (int i = 0; i < HEADER_BYTES; i++)
                hdr_next[i] = '0;
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            bs_reg        <= '0;
            len_lo_reg    <= '0;
            rem_reg       <= '0;
            field_reg     <= '0;
            exp_reg       <= '0;
            pos_reg       <= '0;
            err_reg       <= ST_OK;
            max_alt_reg   <= MAX_ALT_RST;
            max_wrong_reg <= MAX_WRONG_RST;
            for (int i = 0; i < HEADER_BYTES; i++)
                hdr_reg[i] <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bs_reg        <= bs_next;
            len_lo_reg    <= len_lo_next;
            rem_reg       <= rem_next;
            field_reg     <= field_next;
            exp_reg       <= exp_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            max_alt_reg   <= max_alt_next;
            max_wrong_reg <= max_wrong_next;
            hdr_reg       <= hdr_next;
        end
    end

endmodule

// File: rtl/core/lprp_queue.sv
module lprp_queue #(
    parameter int DEPTH = lprp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lprp_pkg::result_t      wr_entry,
    input  logic                   pop,
    output lprp_pkg::result_t      rd_entry,
    output lprp_pkg::queue_stat_t  stat
);
    import lprp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_entry   = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// File: rtl/core/lprp_back.sv
module lprp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lprp_pkg::queue_stat_t              q_stat,
    input  lprp_pkg::result_t                  q_entry,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lprp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [lprp_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                               m_tlast
);
    import lprp_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [OUT_TUSER_W-1:0] user_reg, user_next;
    logic                   last_reg, last_next;
    status_t                st;
    logic [7:0]             diff;
    logic [15:0]            yr;
    logic [7:0]             alt;
    logic [7:0]             wrong;

    // Load the output register when it is empty or being taken
    assign pop = !q_stat.empty && (!valid_reg || m_tready);

    // Keep header and status only on the record end
    always_comb
    begin
        st    = ST_OK;
        diff  = '0;
        yr    = '0;
        alt   = '0;
        wrong = '0;
        if (q_entry.record_done)
        begin
            st    = q_entry.status;
            diff  = q_entry.difficulty;
            yr    = q_entry.year;
            alt   = q_entry.alt_count;
            wrong = q_entry.wrong_count;
        end
    end

    // Pack the result
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            data_next  = {6'b0, wrong, alt, yr, diff, st, q_entry.field_number,
                          q_entry.text_offset, q_entry.text_byte};
            user_next  = {q_entry.field_done, q_entry.text_valid};
            last_next  = q_entry.record_done;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// File: bench/length_prefixed_record_parser_tb.sv
module length_prefixed_record_parser_tb;
    import lprp_pkg::*;

    localparam int          CLK_PERIOD       = 10;
    localparam int          RUN_LIMIT_CYCLES = 200000;
    localparam int unsigned REC_BYTES        = RECORD_BYTES_DEF;
    localparam int          PHASE_BYTES      = 25;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          DIRECTED_ROWS    = 26;

    typedef enum logic [2:0] {
        STAGE_HEADER,
        STAGE_LEN_LO,
        STAGE_LEN_HI,
        STAGE_TEXT,
        STAGE_TAIL,
        STAGE_FAILED
    } stage_t;

    // One request byte waiting to go out, with an optional fixed outcome
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        result_t    pinned_result;
    } offer_t;

    // Directed row; a pinned row carries the whole record outcome
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        pinned;
        status_t     status;
        logic [7:0]  difficulty;
        logic [15:0] year;
        logic [7:0]  alt_count;
        logic [7:0]  wrong_count;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_MAX_ALT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    // Stimulus and expectations
    offer_t  byte_queue[$];
    result_t pending_results[$];
    logic    hold_off = 1'b0;
    logic    calm = 1'b0;
    logic    pressure_go = 1'b0;

    // Parser shadow state
    logic [3:0]  lim_alt = MAX_ALT_RST;
    logic [3:0]  lim_wrong = MAX_WRONG_RST;
    int unsigned rx_count;
    stage_t      stage;
    logic [7:0]  len_lo;
    int unsigned remaining;
    int unsigned field_idx;
    int unsigned field_total;
    int unsigned out_pos;
    logic [7:0]  hdr [HEADER_BYTES];
    status_t     rec_error;

    // Run statistics
    int bytes_taken = 0;
    int records_seen = 0;
    int text_seen = 0;
    int mismatches = 0;
    int status_seen [8];

    row_t directed_rows [DIRECTED_ROWS] = '{
        // single byte: too short
        '{8'hFF, 1'b1, 1'b1, ST_TOO_SHORT,   8'hFF, 16'h0000, 8'h00, 8'h00},
        // five alternates against a limit of four
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h34, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h12, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h05, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b1, 1'b1, ST_COUNT_LIMIT, 8'h00, 16'h1234, 8'h05, 8'h00},
        // good record: empty field, two-byte field, one trailing byte
        '{8'h01, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'hE8, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h07, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h02, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h41, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h42, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h55, 1'b1, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        // maximum field length overflows the buffer, record ends inside it
        '{8'h80, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h00, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b0, ST_OK,          8'h00, 16'h0000, 8'h00, 8'h00},
        '{8'h11, 1'b1, 1'b1, ST_OVERRUN,     8'h80, 16'hFFFF, 8'h00, 8'h00}
    };

    length_prefixed_record_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Clear the per-record shadow state
    function automatic void start_new_record();
        rx_count    = 0;
        stage       = STAGE_HEADER;
        len_lo      = '0;
        remaining   = 0;
        field_idx   = 0;
        field_total = 0;
        out_pos     = 0;
        rec_error   = ST_OK;
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            hdr[i] = '0;
        end
    endfunction

    // Reserve the terminator slot and advance to the next field
    function automatic void close_field();
        out_pos++;
        if (rec_error != ST_OK)
            stage = STAGE_FAILED;
        else if (field_idx + 1 >= field_total)
            stage = STAGE_TAIL;
        else
        begin
            field_idx++;
            stage = STAGE_LEN_LO;
        end
    endfunction

    // Work out the result for one accepted record byte
    function automatic result_t parse_byte(input logic [7:0] b, input logic last);
        result_t     r;
        int unsigned pos;
        int unsigned len;
        r   = '0;
        pos = rx_count;
        if (rx_count <= REC_BYTES)
            rx_count++;

        if (pos >= REC_BYTES)
            stage = STAGE_FAILED;
        else
        begin
            case (stage)
                STAGE_HEADER:
                begin
                    if (pos < HEADER_BYTES)
                        hdr[pos] = b;
                    if (pos >= HEADER_BYTES - 1)
                    begin
                        if (hdr[3] > lim_alt || hdr[4] > lim_wrong)
                        begin
                            rec_error = ST_COUNT_LIMIT;
                            stage     = STAGE_FAILED;
                        end
                        else
                        begin
                            field_total = BASE_FIELDS + hdr[3] + hdr[4];
                            stage       = STAGE_LEN_LO;
                        end
                    end
                end
                STAGE_LEN_LO:
                begin
                    len_lo = b;
                    stage  = STAGE_LEN_HI;
                end
                STAGE_LEN_HI:
                begin
                    len = {b, len_lo};
                    if (out_pos + len + 1 > REC_BYTES)
                        rec_error = ST_OVERFLOW;
                    remaining = len;
                    if (len == 0)
                    begin
                        // empty field: terminator goes at the current offset
                        if (rec_error == ST_OK)
                        begin
                            r.field_done   = 1'b1;
                            r.field_number = field_idx[4:0];
                            r.text_offset  = out_pos[9:0];
                        end
                        close_field();
                    end
                    else
                        stage = STAGE_TEXT;
                end
                STAGE_TEXT:
                begin
                    if (rec_error == ST_OK)
                    begin
                        r.text_valid   = 1'b1;
                        r.text_byte    = b;
                        r.text_offset  = out_pos[9:0];
                        r.field_number = field_idx[4:0];
                    end
                    out_pos++;
                    remaining--;
                    if (remaining == 0)
                    begin
                        if (rec_error == ST_OK)
                            r.field_done = 1'b1;
                        close_field();
                    end
                end
                default:
                begin
                    // tail and failed records drop their bytes
                end
            endcase
        end

        r.record_done = last;
        if (last)
        begin
            if (rx_count > REC_BYTES)
                r.status = ST_TOO_LONG;
            else if (rx_count < HEADER_BYTES)
                r.status = ST_TOO_SHORT;
            else if (rec_error == ST_COUNT_LIMIT)
                r.status = ST_COUNT_LIMIT;
            else if (stage != STAGE_TAIL && stage != STAGE_FAILED)
                r.status = ST_OVERRUN;
            else if (rec_error == ST_OVERFLOW)
                r.status = ST_OVERFLOW;
            else
                r.status = ST_OK;
            r.difficulty  = hdr[0];
            r.year        = {hdr[2], hdr[1]};
            r.alt_count   = hdr[3];
            r.wrong_count = hdr[4];
            start_new_record();
        end
        return r;
    endfunction

    function automatic bit same_result(input result_t e, input result_t a);
        return e.text_valid === a.text_valid && e.text_byte === a.text_byte &&
               e.text_offset === a.text_offset && e.field_number === a.field_number &&
               e.field_done === a.field_done && e.record_done === a.record_done &&
               e.status === a.status && e.difficulty === a.difficulty &&
               e.year === a.year && e.alt_count === a.alt_count &&
               e.wrong_count === a.wrong_count;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf({"tv=%0d byte=%02h off=%0d fld=%0d fd=%0d rd=%0d st=%0d ",
                          "diff=%02h year=%04h alt=%0d wrong=%0d"},
                         r.text_valid, r.text_byte, r.text_offset, r.field_number,
                         r.field_done, r.record_done, r.status, r.difficulty, r.year,
                         r.alt_count, r.wrong_count);
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at %0t: expected %s, got %s", what, $realtime,
                     show_result(want), show_result(got));
    endtask

    // Offer queued request bytes, predict each one as it is taken
    always @(posedge clk)
    begin : send_bytes
        result_t predicted;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = parse_byte(s_tdata, s_tlast);
                if (byte_queue[0].pinned)
                    pending_results.push_back(byte_queue[0].pinned_result);
                else
                    pending_results.push_back(predicted);
                void'(byte_queue.pop_front());
                bytes_taken++;
            end
            // hold an offered request until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 9))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_queue[0].data;
                    s_tlast  <= byte_queue[0].last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Take results and compare them with the oldest prediction
    always @(posedge clk)
    begin : take_results
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.text_valid   = m_tuser[0];
                got.field_done   = m_tuser[1];
                got.record_done  = m_tlast;
                got.text_byte    = m_tdata[7:0];
                got.text_offset  = m_tdata[17:8];
                got.field_number = m_tdata[22:18];
                got.status       = status_t'(m_tdata[25:23]);
                got.difficulty   = m_tdata[33:26];
                got.year         = m_tdata[49:34];
                got.alt_count    = m_tdata[57:50];
                got.wrong_count  = m_tdata[65:58];
                if (pending_results.size() == 0)
                    report_mismatch("nothing pending", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (!same_result(want, got))
                        report_mismatch("field", want, got);
                end
                if (got.text_valid)
                    text_seen++;
                if (got.record_done)
                begin
                    records_seen++;
                    status_seen[got.status]++;
                end
            end
            m_tready <= !hold_off && (calm || $urandom_range(99) >= 9);
        end
    end

    // Hold off the receiver for a long stretch so the result queue fills
    initial
    begin : back_pressure
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stop a run that has hung
    initial
    begin : watchdog
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    task automatic push_byte(input logic [7:0] d);
        offer_t o;
        o      = '0;
        o.data = d;
        byte_queue.push_back(o);
    endtask

    // Mark the newest queued byte as the end of its record
    task automatic end_record();
        offer_t o;
        o      = byte_queue.pop_back();
        o.last = 1'b1;
        byte_queue.push_back(o);
    endtask

    task automatic write_limits(input logic [3:0] alt, input logic [3:0] wrong);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_ALT;
        cfg_data  <= alt;
        @(posedge clk);
        cfg_index <= CFG_MAX_WRONG;
        cfg_data  <= wrong;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_alt   = alt;
        lim_wrong = wrong;
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Queue one random record; mostly well formed, the rest broken or noise
    task automatic queue_random_record(output int n);
        int start;
        int kind;
        int alt;
        int wrong;
        int len;
        int cut;
        start = byte_queue.size();
        kind  = $urandom_range(99);
        alt   = $urandom_range(lim_alt);
        wrong = $urandom_range(lim_wrong);
        if (kind >= 70 && kind < 80)
        begin
            if ($urandom_range(1))
                alt = $urandom_range(255, lim_alt + 1);
            else
                wrong = $urandom_range(255, lim_wrong + 1);
        end
        if (kind < 88)
        begin
            push_byte(8'($urandom));
            push_byte(8'($urandom));
            push_byte(8'($urandom));
            push_byte(alt[7:0]);
            push_byte(wrong[7:0]);
        end

        if (kind < 70)
        begin
            for (int f = 0; f < BASE_FIELDS + alt + wrong; f++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
                push_byte(len[7:0]);
                push_byte(len[15:8]);
                repeat (len) push_byte(8'($urandom));
            end
            repeat ($urandom_range(2)) push_byte(8'($urandom));
            // cut some records short inside a length or a text
            if (kind >= 60)
            begin
                cut = $urandom_range(byte_queue.size() - start - 1, HEADER_BYTES);
                while (byte_queue.size() > start + cut)
                    void'(byte_queue.pop_back());
            end
        end
        else if (kind < 80)
            repeat ($urandom_range(6)) push_byte(8'($urandom));
        else if (kind < 88)
        begin
            // first field longer than the buffer
            push_byte(8'($urandom));
            push_byte(8'($urandom_range(255, 4)));
            repeat ($urandom_range(10)) push_byte(8'($urandom));
        end
        else if (kind < 95)
            repeat ($urandom_range(HEADER_BYTES - 1, 1)) push_byte(8'($urandom));
        else
            repeat ($urandom_range(12, 1)) push_byte(8'($urandom));
        end_record();
        n = byte_queue.size() - start;
    endtask

    // Two-field record of a given size, to reach the top offsets, then extra bytes
    task automatic queue_long_record(input int total, input int extra);
        int len0;
        int len1;
        len0 = $urandom_range(700, 300);
        len1 = total - HEADER_BYTES - 2 * BASE_FIELDS - len0;
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(len0[7:0]);
        push_byte(len0[15:8]);
        repeat (len0) push_byte(8'($urandom));
        push_byte(len1[7:0]);
        push_byte(len1[15:8]);
        repeat (len1) push_byte(8'($urandom));
        repeat (extra) push_byte(8'($urandom));
        end_record();
    endtask

    // Main sequence: reset, directed table, random phases, long record
    initial
    begin : run_test
        offer_t     o;
        row_t       row;
        int         n;
        int         added;
        logic [3:0] alt;
        logic [3:0] wrong;
        start_new_record();
        for (int i = 0; i < 8; i++)
        begin
            status_seen[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at the reset limits
        @(negedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row                         = directed_rows[i];
            o                           = '0;
            o.data                      = row.data;
            o.last                      = row.last;
            o.pinned                    = row.pinned;
            o.pinned_result.record_done = row.last;
            o.pinned_result.status      = row.status;
            o.pinned_result.difficulty  = row.difficulty;
            o.pinned_result.year        = row.year;
            o.pinned_result.alt_count   = row.alt_count;
            o.pinned_result.wrong_count = row.wrong_count;
            byte_queue.push_back(o);
        end
        wait_drained();

        // Random phases over extreme and mid-range limits
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin alt = 4'd0;  wrong = 4'd0;  end
                1: begin alt = 4'd15; wrong = 4'd15; end
                2: begin alt = 4'd15; wrong = 4'd0;  end
                3: begin alt = 4'd0;  wrong = 4'd15; end
                default:
                begin
                    alt   = 4'($urandom_range(14, 1));
                    wrong = 4'($urandom_range(14, 1));
                end
            endcase
            write_limits(alt, wrong);
            calm <= (p == 2);
            @(negedge clk);
            added = 0;
            while (added < PHASE_BYTES)
            begin
                queue_random_record(n);
                added += n;
            end
            wait_drained();
        end
        calm <= 1'b0;

        // Fill the buffer exactly, then run one byte past it; stall the receiver meanwhile
        write_limits(4'($urandom), 4'($urandom));
        @(negedge clk);
        queue_long_record(REC_BYTES, 1);
        pressure_go <= 1'b1;
        wait_drained();

        repeat (20) @(posedge clk);
        $display("covered %0d request bytes in %0d records, %0d text bytes emitted",
                 bytes_taken, records_seen, text_seen);
        $display("outcomes: ok %0d, too long %0d, too short %0d, count %0d, overrun %0d",
                 status_seen[ST_OK], status_seen[ST_TOO_LONG], status_seen[ST_TOO_SHORT],
                 status_seen[ST_COUNT_LIMIT], status_seen[ST_OVERRUN]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
